[rtl/core/multi_alarm_matcher_with_snooze_unit_macros.svh]
// Assertion macros used by the file that checks this block.
`ifndef MULTI_ALARM_MATCHER_WITH_SNOOZE_UNIT_MACROS_SVH
`define MULTI_ALARM_MATCHER_WITH_SNOOZE_UNIT_MACROS_SVH

// Checked on every rising clock edge, and suspended while reset is asserted.
`define MAMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define MAMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/core/mams_pkg.sv]
package mams_pkg;

  localparam int unsigned NumAlarmsDef   = 5;
  localparam int unsigned NumSettingRegs = 5;
  localparam int unsigned OpW            = 3;
  localparam int unsigned MinW           = 11;
  localparam int unsigned DayW           = 3;
  localparam int unsigned IdxInW         = 3;
  localparam int unsigned SoundW         = 2;
  localparam int unsigned SettingW       = 20;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned DayMaskW       = 7;
  localparam int unsigned MinLsb         = 7;
  localparam int unsigned TypeLsb        = 18;
  localparam int unsigned SundayBit      = 6;

  localparam logic [MinW-1:0] SnoozeDelay   = 11'd10;
  localparam logic [MinW-1:0] MinutesPerDay = 11'd1440;

  localparam logic [SoundW-1:0] SoundFile   = 2'd0;
  localparam logic [SoundW-1:0] SoundSpeech = 2'd1;
  localparam logic [SoundW-1:0] SoundBeep   = 2'd2;

  localparam logic [DayW-1:0] DaySunday = 3'd0;
  localparam logic [DayW-1:0] DayNone   = 3'd7;

  typedef enum logic [OpW-1:0] {
    OpTick    = 3'd0,
    OpDismiss = 3'd1,
    OpSnooze  = 3'd2,
    OpEnable  = 3'd3,
    OpDisable = 3'd4
  } op_e;

  // Per-transfer commands broadcast to every cell, already qualified by the accept.
  typedef struct packed {
    logic tick;
    logic dismiss;
    logic snooze;
    logic en;
    logic dis;
  } ctrl_t;

  function automatic logic [SoundW-1:0] sound_of(input logic [SettingW-1:0] s);
    logic [1:0] t;
    t = s[TypeLsb +: 2];
    case (t)
      2'd0:    sound_of = SoundFile;
      2'd1:    sound_of = SoundSpeech;
      default: sound_of = SoundBeep;
    endcase
  endfunction

  // Monday-first one-hot day select; the unused day code selects nothing.
  function automatic logic [DayMaskW-1:0] day_sel(input logic [DayW-1:0] dow);
    day_sel = '0;
    if (dow == DaySunday) begin
      day_sel[SundayBit] = 1'b1;
    end else if (dow != DayNone) begin
      day_sel[dow - 3'd1] = 1'b1;
    end
  endfunction

endpackage

[rtl/core/mams_in_if.sv]
interface mams_in_if;
  logic                        valid;
  logic                        ready;
  logic [mams_pkg::OpW-1:0]    op;
  logic [mams_pkg::MinW-1:0]   minute_of_day;
  logic [mams_pkg::DayW-1:0]   day_of_week;
  logic [mams_pkg::IdxInW-1:0] alarm_index;

  modport source (output valid, op, minute_of_day, day_of_week, alarm_index, input ready);
  modport sink (input valid, op, minute_of_day, day_of_week, alarm_index, output ready);
endinterface

[rtl/core/mams_out_if.sv]
interface mams_out_if;
  logic                        valid;
  logic                        ready;
  logic                        ring;
  logic                        newly_fired;
  logic [mams_pkg::IdxInW-1:0] ringing_index;
  logic [mams_pkg::SoundW-1:0] sound_kind;

  modport source (output valid, ring, newly_fired, ringing_index, sound_kind, input ready);
  modport sink (input valid, ring, newly_fired, ringing_index, sound_kind, output ready);
endinterface

[rtl/core/mams_cfg_if.sv]
interface mams_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mams_pkg::CfgIdxW-1:0]  index;
  logic [mams_pkg::SettingW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/multi_alarm_matcher_with_snooze_unit.sv]
// Throughput: one item per cycle, held while a result waits and out_o.ready is low.
// The match through the cell chain is combinational; each result is registered.
// A new item is taken while a result waits, as long as the output register drains.
// Reset clears all settings, active flags, fired minutes, snooze flags and the
// ringing state; snooze minutes are written before they are read.
module multi_alarm_matcher_with_snooze_unit #(
  parameter int unsigned NUM_ALARMS = mams_pkg::NumAlarmsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  mams_in_if.sink    in_i,
  mams_cfg_if.sink   cfg_i,
  mams_out_if.source out_o
);
  import mams_pkg::*;

  localparam int unsigned IdxW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;

  logic [SettingW-1:0] setting_q [NumSettingRegs];
  logic [SettingW-1:0] alarm_setting [NUM_ALARMS];

  logic              ringing_q;
  logic [IdxW-1:0]   ring_idx_q;
  logic [SoundW-1:0] ring_sound;

  logic              out_valid_q;
  logic              ring_q, ring_d;
  logic              newly_q, newly_d;
  logic [IdxInW-1:0] idx_q, idx_d;
  logic [SoundW-1:0] sound_q, sound_d;

  logic              in_fire;
  op_e               op;
  ctrl_t             ctrl;
  logic [NUM_ALARMS:0]   taken;
  logic [NUM_ALARMS-1:0] grant;
  logic [IdxW-1:0]       grant_idx;
  logic [SoundW-1:0]     grant_sound;
  logic [DayMaskW-1:0]   day_mask;
  logic [MinW:0]         snz_sum;
  logic [MinW-1:0]       snz_min;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSettingRegs; i++) begin
        setting_q[i] <= '0;
      end
    end else if (cfg_i.valid && (32'(cfg_i.index) < NumSettingRegs)) begin
      setting_q[cfg_i.index] <= cfg_i.data;
    end
  end

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign op         = op_e'(in_i.op);

  always_comb begin
    ctrl = '0;
    if (in_fire) begin
      unique case (op)
        OpTick:    ctrl.tick    = !ringing_q;
        OpDismiss: ctrl.dismiss = ringing_q;
        OpSnooze:  ctrl.snooze  = ringing_q;
        OpEnable:  ctrl.en      = 1'b1;
        OpDisable: ctrl.dis     = 1'b1;
        default:   ctrl         = '0;
      endcase
    end
  end

  assign day_mask = day_sel(in_i.day_of_week);
  assign snz_sum  = {1'b0, in_i.minute_of_day} + {1'b0, SnoozeDelay};
  assign snz_min  = (snz_sum >= {1'b0, MinutesPerDay}) ?
                    MinW'(snz_sum - {1'b0, MinutesPerDay}) : snz_sum[MinW-1:0];

  assign taken[0] = 1'b0;

  for (genvar g = 0; g < NUM_ALARMS; g++) begin : g_cell
    if (g < NumSettingRegs) begin : g_reg
      assign alarm_setting[g] = setting_q[g];
    end else begin : g_zero
      assign alarm_setting[g] = '0;
    end

    mams_cell #(
      .Idx  (g),
      .IdxW (IdxW)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .cur_min_i     (in_i.minute_of_day),
      .day_sel_i     (day_mask),
      .alarm_index_i (in_i.alarm_index),
      .ring_idx_i    (ring_idx_q),
      .snooze_min_i  (snz_min),
      .setting_i     (alarm_setting[g]),
      .taken_i       (taken[g]),
      .taken_o       (taken[g+1]),
      .grant_o       (grant[g])
    );
  end

  always_comb begin
    grant_idx   = '0;
    grant_sound = '0;
    ring_sound  = '0;
    for (int i = 0; i < NUM_ALARMS; i++) begin
      if (grant[i]) begin
        grant_idx   = grant_idx | IdxW'(i);
        grant_sound = grant_sound | sound_of(alarm_setting[i]);
      end
      if (ring_idx_q == IdxW'(i)) begin
        ring_sound = sound_of(alarm_setting[i]);
      end
    end
  end

  always_comb begin
    ring_d  = 1'b0;
    newly_d = 1'b0;
    idx_d   = '0;
    sound_d = '0;
    if (op == OpTick) begin
      if (ringing_q) begin
        ring_d  = 1'b1;
        idx_d   = IdxInW'(ring_idx_q);
        sound_d = ring_sound;
      end else if (|grant) begin
        ring_d  = 1'b1;
        newly_d = 1'b1;
        idx_d   = IdxInW'(grant_idx);
        sound_d = grant_sound;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ringing_q  <= 1'b0;
      ring_idx_q <= '0;
    end else if (ctrl.tick && (|grant)) begin
      ringing_q  <= 1'b1;
      ring_idx_q <= grant_idx;
    end else if (ctrl.dismiss || ctrl.snooze) begin
      ringing_q  <= 1'b0;
      ring_idx_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ring_q  <= ring_d;
      newly_q <= newly_d;
      idx_q   <= idx_d;
      sound_q <= sound_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.ring          = ring_q;
  assign out_o.newly_fired   = newly_q;
  assign out_o.ringing_index = idx_q;
  assign out_o.sound_kind    = sound_q;

  `include "multi_alarm_matcher_with_snooze_unit_macros.svh"

  `MAMS_ASSERT_ALWAYS(a_grant_onehot, $onehot0(grant), "More than one alarm fired at once.")
  `MAMS_ASSERT(a_no_fire_ringing, ringing_q |-> (grant == '0), "An alarm fired while ringing.")
  `MAMS_ASSERT(a_fire_rings, (ctrl.tick && (grant != '0)) |=> ringing_q, "Fired without ring.")

endmodule

[rtl/core/mams_cell.sv]
module mams_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned IdxW = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mams_pkg::ctrl_t               ctrl_i,
  input  logic [mams_pkg::MinW-1:0]     cur_min_i,
  input  logic [mams_pkg::DayMaskW-1:0] day_sel_i,
  input  logic [mams_pkg::IdxInW-1:0]   alarm_index_i,
  input  logic [IdxW-1:0]               ring_idx_i,
  input  logic [mams_pkg::MinW-1:0]     snooze_min_i,
  input  logic [mams_pkg::SettingW-1:0] setting_i,
  input  logic                          taken_i,
  output logic                          taken_o,
  output logic                          grant_o
);
  import mams_pkg::*;

  logic            active_q, active_d;
  logic            snz_valid_q, snz_valid_d;
  logic [MinW-1:0] last_q, last_d;
  logic [MinW-1:0] snz_q;
  logic            sel_idx, sel_ring, day_hit, alarm_hit, snz_hit, fire;

  assign sel_idx  = (alarm_index_i == IdxInW'(Idx));
  assign sel_ring = (ring_idx_i == IdxW'(Idx));

  assign day_hit   = |(setting_i[DayMaskW-1:0] & day_sel_i);
  assign alarm_hit = day_hit && (setting_i[MinLsb +: MinW] == cur_min_i);
  assign snz_hit   = snz_valid_q && (snz_q == cur_min_i);
  assign fire      = ctrl_i.tick && active_q && (alarm_hit || snz_hit) &&
                     (last_q != cur_min_i);

  assign grant_o = fire && !taken_i;
  assign taken_o = fire || taken_i;

  always_comb begin
    active_d    = active_q;
    snz_valid_d = snz_valid_q;
    last_d      = last_q;
    if (ctrl_i.en && sel_idx) begin
      active_d = 1'b1;
    end
    if (ctrl_i.dis && sel_idx) begin
      active_d    = 1'b0;
      snz_valid_d = 1'b0;
    end
    if (ctrl_i.snooze && sel_ring) begin
      snz_valid_d = 1'b1;
    end
    if (ctrl_i.dismiss && sel_ring) begin
      snz_valid_d = 1'b0;
    end
    if (grant_o) begin
      last_d = cur_min_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      snz_valid_q <= 1'b0;
      last_q      <= '0;
    end else begin
      active_q    <= active_d;
      snz_valid_q <= snz_valid_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.snooze && sel_ring) begin
      snz_q <= snooze_min_i;
    end
  end

endmodule
